// ===== src/lpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types and codes for the label propagation community detector.
// ----------------------------------------------------------------------------
package lpc_pkg;

	// Operation codes of a command item.
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_RUN   = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} lpc_op_t;

	// Status codes of a response item.
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} lpc_status_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_VERTEX_COUNT    = 2'd0;
	localparam logic [1:0] REG_ITERATION_LIMIT = 2'd1;
	localparam logic [1:0] REG_DIRECTED_MODE   = 2'd2;

	localparam int VID_W = 10;

	// Command item.
	typedef struct packed {
		logic [1:0]       opcode;
		logic [VID_W-1:0] source_vertex;
		logic [VID_W-1:0] target_vertex;
	} lpc_cmd_t;

	// Response item.
	typedef struct packed {
		logic [1:0]       status;
		logic [VID_W-1:0] label;
		logic [15:0]      rounds_done;
		logic             converged;
	} lpc_rsp_t;

	// Field write enables of the vertex memory.
	typedef struct packed {
		logic now;
		logic prev;
		logic tally;
	} lpc_vwe_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_LD_SCAN,
		ST_LD_CHK,
		ST_INIT,
		ST_ROUND,
		ST_CP_RD,
		ST_CP_WR,
		ST_V_START,
		ST_E_RD,
		ST_E_CHK,
		ST_L_WAIT,
		ST_T_WAIT,
		ST_C_RD,
		ST_C_CHK,
		ST_C_LAB,
		ST_V_FIN,
		ST_V_CMP,
		ST_R_END,
		ST_PUT
	} lpc_state_t;

endpackage

// ===== src/label_propagation_communities.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_propagation_communities
// Edge store and label propagation sequencer over two synchronous memories.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on cmd (valid/ready); every command gives exactly one
// response item on rsp (valid/ready). Configuration is written through
// wr_en/wr_index/wr_data; the user must write it only while the block is
// idle, as the block itself does not enforce this. The block works on one
// command at a time; cmd_ready is high in the idle state, also while an
// earlier response still waits in the output register.
// An edge load walks the stored edges through the edge memory port in its
// duplicate search. A run sweeps all MAX_VERTICES words once, then each
// round makes a label copy and, per vertex, a tally pass and a tally clear
// pass over the stored edges, all through the single vertex memory port.
// Reset empties the edge store, sets configuration to its defaults and makes
// every label read return the vertex id until the first run.
// When rsp_ready is low, a finished response waits in the sequencer until
// the output register is free; no response is dropped.
// ----------------------------------------------------------------------------
module label_propagation_communities
	import lpc_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  lpc_cmd_t    cmd,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output lpc_rsp_t    rsp
);

	localparam int VAW  = $clog2(MAX_VERTICES);
	localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ETW  = $clog2(MAX_EDGES + 1);
	localparam int TW   = $clog2(2 * MAX_EDGES + 1);
	localparam int NCAP = (MAX_VERTICES > 2047) ? 2047 : MAX_VERTICES;

	lpc_state_t state_q, state_d;

	logic [10:0]      vcount_q;
	logic [15:0]      limit_q;
	logic             dir_q;
	logic [10:0]      n;

	lpc_cmd_t         cmd_q;
	logic [ETW-1:0]   total_q;
	logic [ETW-1:0]   e_q;
	logic [10:0]      v_q;
	logic [VAW-1:0]   init_q;
	logic [VID_W-1:0] best_q;
	logic [TW-1:0]    bcnt_q;
	logic [1:0]       inc_q;
	logic [VID_W-1:0] lab_q;
	logic             changed_q;
	logic [15:0]      round_q;
	logic             conv_q;
	logic             lab_init_q;
	logic [1:0]       res_status_q;
	logic [VID_W-1:0] res_label_q;
	logic             rsp_valid_q;
	lpc_rsp_t         rsp_q;

	logic [EAW-1:0]   ea;
	logic             ewe;
	logic [19:0]      erd;
	logic [VAW-1:0]   va;
	lpc_vwe_t         vwe;
	logic [VID_W-1:0] wnow, wbefore;
	logic [TW-1:0]    wtally;
	logic [VID_W-1:0] rnow, rbefore;
	logic [TW-1:0]    rtally;

	logic [VID_W-1:0] es, et, nbr;
	logic             s_is_v, t_is_v, hit;
	logic [1:0]       inc_d;
	logic [TW-1:0]    tsum;
	logic             more_edges, slot_free, cmd_bad;

	// Active vertex count, saturated at the vertex capacity.
	assign n = (vcount_q > 11'(NCAP)) ? 11'(NCAP) : vcount_q;

	// Neighbor decode of the edge word just read.
	assign es     = erd[19:10];
	assign et     = erd[9:0];
	assign s_is_v = (11'(es) == v_q);
	assign t_is_v = (11'(et) == v_q);
	assign hit    = (11'(es) < n) && (11'(et) < n) && (s_is_v || (dir_q && t_is_v));
	assign nbr    = s_is_v ? et : es;
	assign inc_d  = (s_is_v && dir_q && t_is_v) ? 2'd2 : 2'd1;

	assign tsum       = rtally + TW'(inc_q);
	assign more_edges = (e_q < total_q);
	assign slot_free  = !rsp_valid_q || rsp_ready;
	assign cmd_bad    = (11'(cmd.source_vertex) >= n) || (11'(cmd.target_vertex) >= n);

	assign cmd_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	lpc_edge_mem #(
		.DEPTH(MAX_EDGES),
		.AW   (EAW)
	) u_edge_mem (
		.clk  (clk),
		.addr (ea),
		.we   (ewe),
		.wdata({cmd_q.source_vertex, cmd_q.target_vertex}),
		.rdata(erd)
	);

	lpc_vert_mem #(
		.DEPTH(MAX_VERTICES),
		.AW   (VAW),
		.TW   (TW)
	) u_vert_mem (
		.clk    (clk),
		.addr   (va),
		.we     (vwe),
		.wnow   (wnow),
		.wbefore(wbefore),
		.wtally (wtally),
		.rnow   (rnow),
		.rbefore(rbefore),
		.rtally (rtally)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port control.
	always_comb begin
		state_d = state_q;
		ea      = e_q[EAW-1:0];
		ewe     = 1'b0;
		va      = VAW'(v_q);
		vwe     = '0;
		wnow    = best_q;
		wbefore = rnow;
		wtally  = '0;
		unique case (state_q)
			ST_IDLE: begin
				va = VAW'(cmd.source_vertex);
				if (cmd_valid) begin
					unique case (lpc_op_t'(cmd.opcode))
						OP_LOAD:  state_d = cmd_bad ? ST_PUT : ST_LD_SCAN;
						OP_RUN:   state_d = ST_INIT;
						OP_READ: begin
							if ((11'(cmd.source_vertex) >= n) || !lab_init_q) begin
								state_d = ST_PUT;
							end else begin
								state_d = ST_RD_WAIT;
							end
						end
						OP_CLEAR: state_d = ST_PUT;
						default:  state_d = ST_PUT;
					endcase
				end
			end
			ST_RD_WAIT: state_d = ST_PUT;
			ST_LD_SCAN: begin
				if (more_edges) begin
					state_d = ST_LD_CHK;
				end else begin
					ea      = total_q[EAW-1:0];
					ewe     = (total_q != ETW'(MAX_EDGES));
					state_d = ST_PUT;
				end
			end
			ST_LD_CHK: begin
				state_d = (erd == {cmd_q.source_vertex, cmd_q.target_vertex}) ?
					ST_PUT : ST_LD_SCAN;
			end
			// Every vertex word gets its id as label and a zero tally.
			ST_INIT: begin
				va        = init_q;
				vwe.now   = 1'b1;
				vwe.tally = 1'b1;
				wnow      = VID_W'(init_q);
				if (init_q == VAW'(MAX_VERTICES - 1)) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: state_d = (round_q < limit_q) ? ST_CP_RD : ST_PUT;
			ST_CP_RD: state_d = (v_q < n) ? ST_CP_WR : ST_V_START;
			ST_CP_WR: begin
				vwe.prev = 1'b1;
				state_d  = ST_CP_RD;
			end
			ST_V_START: state_d = (v_q < n) ? ST_E_RD : ST_R_END;
			ST_E_RD: begin
				if (more_edges) begin
					state_d = ST_E_CHK;
				end else if (bcnt_q == '0) begin
					state_d = ST_V_START;
				end else begin
					state_d = ST_C_RD;
				end
			end
			ST_E_CHK: begin
				va      = VAW'(nbr);
				state_d = hit ? ST_L_WAIT : ST_E_RD;
			end
			ST_L_WAIT: begin
				va      = VAW'(rbefore);
				state_d = ST_T_WAIT;
			end
			ST_T_WAIT: begin
				va        = VAW'(lab_q);
				vwe.tally = 1'b1;
				wtally    = tsum;
				state_d   = ST_E_RD;
			end
			ST_C_RD: state_d = more_edges ? ST_C_CHK : ST_V_FIN;
			ST_C_CHK: begin
				va      = VAW'(nbr);
				state_d = hit ? ST_C_LAB : ST_C_RD;
			end
			ST_C_LAB: begin
				va        = VAW'(rbefore);
				vwe.tally = 1'b1;
				state_d   = ST_C_RD;
			end
			ST_V_FIN: state_d = ST_V_CMP;
			ST_V_CMP: begin
				vwe.now = 1'b1;
				state_d = ST_V_START;
			end
			ST_R_END: state_d = changed_q ? ST_ROUND : ST_PUT;
			ST_PUT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Configuration, edge count, run results and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q    <= 11'd1024;
			limit_q     <= 16'd10;
			dir_q       <= 1'b0;
			total_q     <= '0;
			round_q     <= '0;
			conv_q      <= 1'b0;
			lab_init_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_VERTEX_COUNT:    vcount_q <= wr_data[10:0];
					REG_ITERATION_LIMIT: limit_q  <= wr_data;
					REG_DIRECTED_MODE:   dir_q    <= wr_data[0];
					default: ;
				endcase
			end
			// A new response fills the output register; an accepted one leaves it.
			if ((state_q == ST_PUT) && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid && (lpc_op_t'(cmd.opcode) == OP_CLEAR)) begin
						total_q <= '0;
					end
				end
				ST_LD_SCAN: begin
					if (!more_edges && (total_q != ETW'(MAX_EDGES))) begin
						total_q <= total_q + 1'b1;
					end
				end
				ST_INIT: begin
					if (init_q == VAW'(MAX_VERTICES - 1)) begin
						lab_init_q <= 1'b1;
						round_q    <= '0;
						conv_q     <= 1'b0;
					end
				end
				ST_R_END: begin
					round_q <= round_q + 1'b1;
					if (!changed_q) begin
						conv_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q  <= cmd;
				e_q    <= '0;
				init_q <= '0;
				if (((lpc_op_t'(cmd.opcode) == OP_LOAD) && cmd_bad) ||
				    ((lpc_op_t'(cmd.opcode) == OP_READ) &&
				     (11'(cmd.source_vertex) >= n))) begin
					res_status_q <= STAT_RANGE;
				end else begin
					res_status_q <= STAT_OK;
				end
				if ((lpc_op_t'(cmd.opcode) == OP_READ) && (11'(cmd.source_vertex) < n)) begin
					res_label_q <= cmd.source_vertex;
				end else begin
					res_label_q <= '0;
				end
			end
			ST_RD_WAIT: res_label_q <= rnow;
			ST_LD_SCAN: begin
				if (!more_edges && (total_q == ETW'(MAX_EDGES))) begin
					res_status_q <= STAT_FULL;
				end
			end
			ST_LD_CHK:  e_q <= e_q + 1'b1;
			ST_INIT:    init_q <= init_q + 1'b1;
			ST_ROUND: begin
				v_q       <= '0;
				changed_q <= 1'b0;
			end
			ST_CP_RD: begin
				if (v_q >= n) begin
					v_q <= '0;
				end
			end
			ST_CP_WR:   v_q <= v_q + 1'b1;
			ST_V_START: begin
				e_q    <= '0;
				best_q <= '0;
				bcnt_q <= '0;
			end
			ST_E_RD: begin
				if (!more_edges) begin
					e_q <= '0;
					if (bcnt_q == '0) begin
						v_q <= v_q + 1'b1;
					end
				end
			end
			ST_E_CHK: begin
				e_q   <= e_q + 1'b1;
				inc_q <= inc_d;
			end
			ST_L_WAIT:  lab_q <= rbefore;
			// Most frequent label so far, the smaller one on a tie.
			ST_T_WAIT: begin
				if ((tsum > bcnt_q) || ((tsum == bcnt_q) && (lab_q < best_q))) begin
					best_q <= lab_q;
					bcnt_q <= tsum;
				end
			end
			ST_C_CHK:   e_q <= e_q + 1'b1;
			ST_V_CMP: begin
				if (best_q != rbefore) begin
					changed_q <= 1'b1;
				end
				v_q <= v_q + 1'b1;
			end
			ST_PUT: begin
				if (slot_free) begin
					rsp_q.status      <= res_status_q;
					rsp_q.label       <= res_label_q;
					rsp_q.rounds_done <= round_q;
					rsp_q.converged   <= conv_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	// The edge count never passes the store capacity.
	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= ETW'(MAX_EDGES))
		else $error("edge count beyond capacity");

	// A converged run has performed at least one round.
	a_conv_round: assert property (@(posedge clk) disable iff (!arst_n)
		conv_q |-> (round_q != '0))
		else $error("converged without a round");

	// The vertex memory is never written while idle.
	a_idle_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (vwe == '0))
		else $error("vertex memory written while idle");
`endif

endmodule

// ===== src/lpc_edge_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_edge_mem
// Single-port edge store, one edge per word, registered read data.
// ----------------------------------------------------------------------------
module lpc_edge_mem #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13
) (
	input  logic          clk,
	input  logic [AW-1:0] addr,
	input  logic          we,
	input  logic [19:0]   wdata,
	output logic [19:0]   rdata
);

	logic [19:0] mem [DEPTH];

	// Write when enabled; the addressed word is read every cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== src/lpc_vert_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_vert_mem
// Per-vertex memory holding the current label, the previous round's label
// and the label tally, with a write enable for each field.
// ----------------------------------------------------------------------------
module lpc_vert_mem
	import lpc_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int TW    = 15
) (
	input  logic             clk,
	input  logic [AW-1:0]    addr,
	input  lpc_vwe_t         we,
	input  logic [VID_W-1:0] wnow,
	input  logic [VID_W-1:0] wbefore,
	input  logic [TW-1:0]    wtally,
	output logic [VID_W-1:0] rnow,
	output logic [VID_W-1:0] rbefore,
	output logic [TW-1:0]    rtally
);

	localparam int WW = 2 * VID_W + TW;

	logic [WW-1:0] mem [DEPTH];
	logic [WW-1:0] rd_q;

	// Field-wise writes and a registered read of the addressed word.
	always_ff @(posedge clk) begin
		if (we.now) begin
			mem[addr][WW-1 -: VID_W] <= wnow;
		end
		if (we.prev) begin
			mem[addr][TW +: VID_W] <= wbefore;
		end
		if (we.tally) begin
			mem[addr][TW-1:0] <= wtally;
		end
		rd_q <= mem[addr];
	end

	assign rnow    = rd_q[WW-1 -: VID_W];
	assign rbefore = rd_q[TW +: VID_W];
	assign rtally  = rd_q[TW-1:0];

endmodule
